### hdl/dltq_pkg.sv
// Package: request/result types, command and result codes for the timeout queue.
package dltq_pkg;

    localparam int DELTA_W     = 24;
    localparam int MAX_RESULTS = 16;
    localparam logic [DELTA_W-1:0] DELTA_MAX = {DELTA_W{1'b1}};

    // Request commands
    localparam logic [1:0] CMD_TICK       = 2'd0;
    localparam logic [1:0] CMD_SCHEDULE   = 2'd1;
    localparam logic [1:0] CMD_UNSCHEDULE = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_EXPIRED   = 2'd0;
    localparam logic [1:0] KIND_SCHEDULED = 2'd1;
    localparam logic [1:0] KIND_REJECTED  = 2'd2;
    localparam logic [1:0] KIND_UNSCHED   = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        timeout_id;
        logic [7:0]         owner_id;
        logic [DELTA_W-1:0] interval;
    } dltq_req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] out_timeout_id;
        logic [7:0]  out_owner_id;
        logic [4:0]  removed_count;
        logic        last;
    } dltq_rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       idx_inc;
        logic       rel_sub;
        logic       wr_delta;
        logic       insert;
        logic       ins_zero;
        logic       drop;
        logic       merge;
        logic       head_sub;
        logic       drop_head;
        logic       emit;
        logic [1:0] emit_kind;
    } dltq_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic at_end;
        logic full;
        logic empty;
        logic rel_gt;
        logic rel_lt;
        logic d_zero;
        logic match;
        logic head_zero;
        logic k_max;
        logic out_free;
        logic rej;
    } dltq_sts_t;

endpackage

### hdl/delta_list_timeout_queue.sv
// Top level: delta-list timeout queue with controller and slot datapath.
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | in_data  (dltq_req_t)
//   out     | output    | out_valid / out_ready  | out_data (dltq_rsp_t)
//   cfg     | input     | cfg_we                 | cfg_wdata (tick interval)
// One request at a time: in_ready is high only while the controller is idle.
// A schedule walks the list one slot a cycle until it finds its place; an
// unschedule walks the whole list and drops every matching slot; a tick takes
// the tick interval off the head delta, then expires each zero-delta head slot.
// Reset empties the list and sets the tick interval to 1.
// A stalled result holds the controller in its emit state until taken.
module delta_list_timeout_queue
    import dltq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic      in_valid,
    output logic      in_ready,
    input  dltq_req_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output dltq_rsp_t out_data
);

    dltq_ctl_t ctl;
    dltq_sts_t sts;

    dltq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (in_data.cmd),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    dltq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

### hdl/dltq_ctrl.sv
// Controller: sequences tick, schedule and unschedule walks over the slot list.
module dltq_ctrl
    import dltq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic [1:0] in_cmd,
    output logic      in_ready,
    input  dltq_sts_t sts,
    output dltq_ctl_t ctl
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_TICK_SUB  = 4'd1;
    localparam logic [3:0] ST_TICK_FIRE = 4'd2;
    localparam logic [3:0] ST_SCH_WALK  = 4'd3;
    localparam logic [3:0] ST_SCH_INS   = 4'd4;
    localparam logic [3:0] ST_SCH_SKIP  = 4'd5;
    localparam logic [3:0] ST_SCH_DONE  = 4'd6;
    localparam logic [3:0] ST_UNS_WALK  = 4'd7;
    localparam logic [3:0] ST_UNS_MERGE = 4'd8;
    localparam logic [3:0] ST_UNS_DONE  = 4'd9;

    logic [3:0] state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    if (in_cmd == CMD_TICK)
                        state_next = ST_TICK_SUB;
                    else if (in_cmd == CMD_SCHEDULE)
                        state_next = sts.full ? ST_SCH_DONE : ST_SCH_WALK;
                    else if (in_cmd == CMD_UNSCHEDULE)
                        state_next = ST_UNS_WALK;
                end
            end
            ST_TICK_SUB:
            begin
                ctl.head_sub = !sts.empty && !sts.head_zero;
                state_next   = ST_TICK_FIRE;
            end
            ST_TICK_FIRE:
            begin
                if (sts.empty || !sts.head_zero || sts.k_max)
                    state_next = ST_IDLE;
                else if (sts.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = KIND_EXPIRED;
                    ctl.drop_head = 1'b1;
                end
            end
            ST_SCH_WALK:
            begin
                if (sts.at_end)
                begin
                    ctl.insert = 1'b1;
                    state_next = ST_SCH_DONE;
                end
                else if (sts.rel_gt)
                begin
                    ctl.rel_sub = 1'b1;
                    ctl.idx_inc = 1'b1;
                end
                else if (sts.rel_lt)
                begin
                    ctl.wr_delta = 1'b1;
                    state_next   = ST_SCH_INS;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                    state_next  = ST_SCH_SKIP;
                end
            end
            ST_SCH_INS:
            begin
                ctl.insert = 1'b1;
                state_next = ST_SCH_DONE;
            end
            ST_SCH_SKIP:
            begin
                if (!sts.at_end && sts.d_zero)
                    ctl.idx_inc = 1'b1;
                else
                begin
                    ctl.insert   = 1'b1;
                    ctl.ins_zero = 1'b1;
                    state_next   = ST_SCH_DONE;
                end
            end
            ST_SCH_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = sts.rej ? KIND_REJECTED : KIND_SCHEDULED;
                    state_next    = ST_IDLE;
                end
            end
            ST_UNS_WALK:
            begin
                if (sts.at_end)
                    state_next = ST_UNS_DONE;
                else if (sts.match)
                begin
                    ctl.drop   = 1'b1;
                    state_next = ST_UNS_MERGE;
                end
                else
                    ctl.idx_inc = 1'b1;
            end
            ST_UNS_MERGE:
            begin
                ctl.merge  = !sts.at_end;
                state_next = ST_UNS_WALK;
            end
            ST_UNS_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = KIND_UNSCHED;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### hdl/dltq_datapath.sv
// Datapath: slot registers, walk index, remaining interval and result register.
module dltq_datapath
    import dltq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  dltq_req_t  in_data,
    input  logic       out_ready,
    output logic       out_valid,
    output dltq_rsp_t  out_data,
    input  dltq_ctl_t  ctl,
    output dltq_sts_t  sts
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    logic [15:0]        id_reg   [QUEUE_DEPTH];
    logic [7:0]         own_reg  [QUEUE_DEPTH];
    logic [DELTA_W-1:0] dlt_reg  [QUEUE_DEPTH];
    logic [15:0]        id_next  [QUEUE_DEPTH];
    logic [7:0]         own_next [QUEUE_DEPTH];
    logic [DELTA_W-1:0] dlt_next [QUEUE_DEPTH];

    dltq_req_t          req_reg;
    logic [DELTA_W-1:0] rel_reg, carry_reg;
    logic [CW-1:0]      idx_reg, cnt_reg, cnt_next;
    logic [4:0]         k_reg, rem_reg;
    logic               rej_reg;
    logic [7:0]         tick_reg;
    logic               out_valid_reg;
    dltq_rsp_t          out_reg;

    logic [IW-1:0]      ia;
    logic [DELTA_W-1:0] d_idx, head_sub_val, ins_delta;
    logic [DELTA_W:0]   merge_sum;
    logic [DELTA_W-1:0] merge_val;
    logic               tick_last;

    // Read the slot under the walk index
    assign ia    = idx_reg[IW-1:0];
    assign d_idx = dlt_reg[ia];

    assign merge_sum    = {1'b0, d_idx} + {1'b0, carry_reg};
    assign merge_val    = merge_sum[DELTA_W] ? DELTA_MAX : merge_sum[DELTA_W-1:0];
    assign head_sub_val = (dlt_reg[0] > DELTA_W'(tick_reg)) ?
                          dlt_reg[0] - DELTA_W'(tick_reg) : '0;
    assign ins_delta    = ctl.ins_zero ? '0 : rel_reg;

    // Status back to the controller
    always_comb
    begin
        sts.at_end    = idx_reg >= cnt_reg;
        sts.full      = cnt_reg == CW'(QUEUE_DEPTH);
        sts.empty     = cnt_reg == '0;
        sts.rel_gt    = rel_reg > d_idx;
        sts.rel_lt    = rel_reg < d_idx;
        sts.d_zero    = d_idx == '0;
        sts.match     = (id_reg[ia] == req_reg.timeout_id) && (own_reg[ia] == req_reg.owner_id);
        sts.head_zero = dlt_reg[0] == '0;
        sts.k_max     = k_reg == 5'(MAX_RESULTS);
        sts.out_free  = !out_valid_reg || out_ready;
        sts.rej       = rej_reg;
    end

    // Shift, insert and update the slots
    always_comb
    begin
        cnt_next = cnt_reg;
        for (int j = 0; j < QUEUE_DEPTH; j++)
        begin
            id_next[j]  = id_reg[j];
            own_next[j] = own_reg[j];
            dlt_next[j] = dlt_reg[j];
            if (ctl.insert)
            begin
                if (j > 0 && CW'(j) > idx_reg)
                begin
                    id_next[j]  = id_reg[j-1];
                    own_next[j] = own_reg[j-1];
                    dlt_next[j] = dlt_reg[j-1];
                end
                else if (CW'(j) == idx_reg)
                begin
                    id_next[j]  = req_reg.timeout_id;
                    own_next[j] = req_reg.owner_id;
                    dlt_next[j] = ins_delta;
                end
            end
            if ((ctl.drop && CW'(j) >= idx_reg) || ctl.drop_head)
            begin
                if (j < QUEUE_DEPTH - 1)
                begin
                    id_next[j]  = id_reg[j+1];
                    own_next[j] = own_reg[j+1];
                    dlt_next[j] = dlt_reg[j+1];
                end
            end
            if (ctl.wr_delta && CW'(j) == idx_reg)
                dlt_next[j] = d_idx - rel_reg;
            if (ctl.merge && CW'(j) == idx_reg)
                dlt_next[j] = merge_val;
            if (ctl.head_sub && j == 0)
                dlt_next[j] = head_sub_val;
        end
        if (ctl.insert)
            cnt_next = cnt_reg + 1'b1;
        else if (ctl.drop || ctl.drop_head)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < QUEUE_DEPTH; j++)
        begin
            id_reg[j]  <= id_next[j];
            own_reg[j] <= own_next[j];
            dlt_reg[j] <= dlt_next[j];
        end
    end

    // Expiry is last when no zero-delta successor follows or the tick quota runs out
    assign tick_last = (cnt_reg == CW'(1)) || (dlt_reg[1] != '0) ||
                       (k_reg == 5'(MAX_RESULTS - 1));

    // Hold the request and walk state
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_reg <= in_data;
            rel_reg <= in_data.interval;
        end
        else if (ctl.rel_sub)
            rel_reg <= rel_reg - d_idx;
        if (ctl.drop)
            carry_reg <= d_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            k_reg         <= '0;
            rem_reg       <= '0;
            rej_reg       <= 1'b0;
            tick_reg      <= 8'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cfg_we)
                tick_reg <= cfg_wdata;
            if (ctl.load)
            begin
                idx_reg <= '0;
                k_reg   <= '0;
                rem_reg <= '0;
                rej_reg <= (cnt_reg == CW'(QUEUE_DEPTH));
            end
            else
            begin
                if (ctl.idx_inc)
                    idx_reg <= idx_reg + 1'b1;
                if (ctl.drop && rem_reg != 5'd31)
                    rem_reg <= rem_reg + 1'b1;
                if (ctl.drop_head)
                    k_reg <= k_reg + 1'b1;
            end
            if (ctl.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_reg.kind <= ctl.emit_kind;
            if (ctl.emit_kind == KIND_EXPIRED)
            begin
                out_reg.out_timeout_id <= id_reg[0];
                out_reg.out_owner_id   <= own_reg[0];
                out_reg.last           <= tick_last;
            end
            else
            begin
                out_reg.out_timeout_id <= req_reg.timeout_id;
                out_reg.out_owner_id   <= req_reg.owner_id;
                out_reg.last           <= 1'b1;
            end
            out_reg.removed_count <= (ctl.emit_kind == KIND_UNSCHED) ? rem_reg : 5'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(QUEUE_DEPTH))
        else $error("slot count beyond depth");
    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.insert |-> cnt_reg < CW'(QUEUE_DEPTH))
        else $error("insert into full list");
    a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.drop || ctl.drop_head) |-> cnt_reg != '0)
        else $error("drop from empty list");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten");

endmodule
